/* rtl/core/sha512_pkg.sv */
// Package for the SHA-512 streaming hasher: beat types, constants and round functions.
package sha512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_item;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Job handed from the front part to the compression engine.
  typedef struct packed {
    logic [15:0][63:0] block;
    logic              final_block;
  } job_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_ADD,
    ENG_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    FR_LOAD,
    FR_PAD,
    FR_LEN
  } front_state_t;

  localparam logic [7:0][63:0] INIT_VALUE = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam int QUEUE_DEPTH = 2;

  function automatic logic [63:0] round_const(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

endpackage

/* rtl/core/sha512_hash_top.sv */
// Top level of the streaming SHA-512 hasher.
// Each 16-word block passes the compression engine as a load, 80 rounds (one per
// cycle) and a final add. A final word adds one or two padded blocks, then eight
// digest beats, one per cycle while the output is not stalled.
// The two-entry job queue lets the front part take words while a block compresses.
// Synchronous active-high reset restores the initial hash value and empties all.
module sha512_hash_top import sha512_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_data,
  input  logic      in_valid,
  output logic      in_stall,
  output out_beat_t out_data,
  output logic      out_valid,
  input  logic      out_stall
);

  // Jobs carry a full message block plus a flag that marks the last block of a message.
  job_t fr_job, q_job;
  logic fr_valid, fr_stall, q_valid, q_stall;

  sha512_front u_front (
    .clk(clk), .rst(rst), .in_beat(in_data), .in_valid(in_valid), .in_stall(in_stall),
    .job(fr_job), .job_valid(fr_valid), .job_stall(fr_stall)
  );

  sha512_queue u_queue (
    .clk(clk), .rst(rst), .wr_job(fr_job), .wr_valid(fr_valid), .wr_stall(fr_stall),
    .rd_job(q_job), .rd_valid(q_valid), .rd_stall(q_stall)
  );

  // The engine holds the chaining value and streams the digest beat by beat.
  sha512_engine u_engine (
    .clk(clk), .rst(rst), .job(q_job), .job_valid(q_valid), .job_stall(q_stall),
    .out_beat(out_data), .out_valid(out_valid), .out_stall(out_stall)
  );

`ifndef SYNTHESIS
  // A stalled digest beat must hold its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("digest beat changed while stalled");

  // Digest beat indexes advance by one when a beat moves on.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_word && out_valid |=>
      !out_valid || out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest beat index skipped");

  // The last flag appears only on the eighth word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag on wrong digest word");
`endif

endmodule

/* rtl/core/sha512_front.sv */
// Front part: gathers words into blocks, applies padding and the length.
module sha512_front import sha512_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_beat_t in_beat,
  input  logic     in_valid,
  output logic     in_stall,
  output job_t     job,
  output logic     job_valid,
  input  logic     job_stall
);

  front_state_t      state, state_next;
  logic [15:0][63:0] block;
  logic [3:0]        word_position;
  logic [60:0]       byte_total;
  logic [3:0]        count;
  logic [63:0]       keep;
  logic [63:0]       masked;
  logic [7:0]        used;
  logic [63:0]       msg_bits;
  logic              take;
  logic              job_load;

  assign count    = (in_beat.byte_count > 4'd8) ? 4'd8 : in_beat.byte_count;
  assign keep     = (count == 4'd0) ? 64'h0 : ~64'h0 << (7'd64 - {count, 3'b000});
  assign masked   = (in_beat.data_word & keep) | ((count == 4'd8) ? 64'h0 :
                    (64'h80 << (6'd56 - {count[2:0], 3'b000})));
  assign used     = {1'b0, word_position, 3'b000} + {4'b0000, count};
  assign msg_bits = {byte_total + {57'd0, count}, 3'b000};
  assign in_stall = (state != FR_LOAD) || (job_valid && job_stall);
  assign take     = in_valid && !in_stall;
  assign job_load = (take && (in_beat.last_item || word_position == 4'd15)) ||
                    ((state != FR_LOAD) && !(job_valid && job_stall));

  always_comb begin
    state_next = state;
    case (state)
      FR_LOAD: begin
        if (take && in_beat.last_item) begin
          if (used == 8'd128) begin
            state_next = FR_PAD;
          end else if (used >= 8'd112) begin
            state_next = FR_LEN;
          end
        end
      end
      FR_PAD, FR_LEN: begin
        if (!(job_valid && job_stall)) begin
          state_next = FR_LOAD;
        end
      end
      default: state_next = FR_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FR_LOAD;
      word_position <= '0;
      byte_total    <= '0;
      job_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      job_valid <= job_load || (job_valid && job_stall);
      if (take && !in_beat.last_item) begin
        block[word_position] <= in_beat.data_word;
        byte_total           <= byte_total + 61'd8;
        word_position        <= word_position + 4'd1;
        if (word_position == 4'd15) begin
          job.block             <= {in_beat.data_word, block[14:0]};
          job.final_block       <= 1'b0;
        end
      end else if (take) begin
        // Final word: marker lands in this word unless it is full, else in the next one.
        word_position <= '0;
        byte_total    <= '0;
        for (int i = 0; i < 16; i++) begin
          if (i >= 14 && used < 8'd112) begin
            job.block[i] <= (i == 15) ? msg_bits : 64'h0;
          end else if (i == int'(word_position)) begin
            job.block[i] <= masked;
          end else if (i == int'(word_position) + 1 && count == 4'd8) begin
            job.block[i] <= 64'h8000000000000000;
          end else if (i > int'(word_position)) begin
            job.block[i] <= 64'h0;
          end else begin
            job.block[i] <= block[i];
          end
        end
        job.final_block <= (used < 8'd112);
        block[15]       <= msg_bits;
      end else if (state != FR_LOAD && !(job_valid && job_stall)) begin
        // Extra block: marker word first when the data filled the block.
        for (int i = 0; i < 16; i++) begin
          if (i == 15) begin
            job.block[i] <= block[15];
          end else if (i == 0 && state == FR_PAD) begin
            job.block[i] <= 64'h8000000000000000;
          end else begin
            job.block[i] <= 64'h0;
          end
        end
        job.final_block <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/sha512_queue.sv */
// Short job queue between the front part and the compression engine.
module sha512_queue import sha512_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t wr_job,
  input  logic wr_valid,
  output logic wr_stall,
  output job_t rd_job,
  output logic rd_valid,
  input  logic rd_stall
);

  job_t       slots [QUEUE_DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign wr_stall = (fill == 2'(QUEUE_DEPTH));
  assign rd_valid = (fill != 2'd0);
  assign rd_job   = slots[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/sha512_engine.sv */
// Back part: 80-round compression, one round per cycle, and digest output.
module sha512_engine import sha512_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_valid,
  output logic      job_stall,
  output out_beat_t out_beat,
  output logic      out_valid,
  input  logic      out_stall
);

  eng_state_t        state, state_next;
  logic [7:0][63:0]  hash;
  logic [7:0][63:0]  work;
  logic [15:0][63:0] sched;
  logic [6:0]        round;
  logic              final_block;
  logic [2:0]        emit_idx;
  logic [63:0]       t1, t2, w_new, s0, s1;
  logic [63:0]       ea, ee;

  assign job_stall = (state != ENG_IDLE);

  assign ea = work[0];
  assign ee = work[4];
  assign t1 = work[7] + (rotr(ee, 14) ^ rotr(ee, 18) ^ rotr(ee, 41))
            + ((ee & work[5]) ^ (~ee & work[6])) + round_const(round) + sched[0];
  assign t2 = (rotr(ea, 28) ^ rotr(ea, 34) ^ rotr(ea, 39))
            + ((ea & work[1]) ^ (ea & work[2]) ^ (work[1] & work[2]));
  assign s0 = rotr(sched[1], 1) ^ rotr(sched[1], 8) ^ (sched[1] >> 7);
  assign s1 = rotr(sched[14], 19) ^ rotr(sched[14], 61) ^ (sched[14] >> 6);
  assign w_new = s1 + sched[9] + s0 + sched[0];

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE:  if (job_valid) state_next = ENG_ROUND;
      ENG_ROUND: if (round == 7'd79) state_next = ENG_ADD;
      ENG_ADD:   state_next = final_block ? ENG_EMIT : ENG_IDLE;
      ENG_EMIT:  if (!(out_valid && out_stall) && emit_idx == 3'd7 && out_valid)
                   state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      hash      <= INIT_VALUE;
      out_valid <= 1'b0;
      emit_idx  <= '0;
      round     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ENG_IDLE: begin
          if (job_valid) begin
            sched       <= job.block;
            final_block <= job.final_block;
            work        <= hash;
            round       <= '0;
          end
        end
        ENG_ROUND: begin
          work  <= {work[6], work[5], work[4], work[3] + t1,
                    work[2], work[1], work[0], t1 + t2};
          sched <= {w_new, sched[15:1]};
          round <= round + 7'd1;
        end
        ENG_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          emit_idx <= '0;
        end
        ENG_EMIT: begin
          // Beats are only valid in this state, so the last beat's acceptance clears valid.
          if (!out_valid || !out_stall) begin
            if (out_valid && emit_idx == 3'd7) begin
              hash      <= INIT_VALUE;
              out_valid <= 1'b0;
            end else begin
              out_beat.digest_word <= hash[emit_idx + {2'b00, out_valid}];
              out_beat.word_index  <= emit_idx + {2'b00, out_valid};
              out_beat.last_word   <= (emit_idx + {2'b00, out_valid}) == 3'd7;
              emit_idx             <= emit_idx + {2'b00, out_valid};
              out_valid            <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
